// ----- design/tmf_pkg.sv -----
// Shared types and constants of the four-channel trimmed-mean filter.
// No dependencies; compile first.
package tmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHANNELS = 4;

    // Lane order inside the datapath
    localparam int LANE_FRONT     = 0;
    localparam int LANE_BACK      = 1;
    localparam int LANE_RIGHT_ONE = 2;
    localparam int LANE_RIGHT_TWO = 3;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Stage enables shared by all lanes, which run in lockstep
    typedef struct packed {
        logic wr_en;
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } lane_ctrl_t;

endpackage

// ----- design/tmf_sample_if.sv -----
// Input channel of the trimmed-mean filter: one beat carries four readings.
// Depends on tmf_pkg.
interface tmf_sample_if
    import tmf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t front_sample;
    sample_t back_sample;
    sample_t right_one_sample;
    sample_t right_two_sample;

    modport source (
        output valid,
        input  ready,
        output front_sample,
        output back_sample,
        output right_one_sample,
        output right_two_sample
    );

    modport sink (
        input  valid,
        output ready,
        input  front_sample,
        input  back_sample,
        input  right_one_sample,
        input  right_two_sample
    );
endinterface

// ----- design/tmf_result_if.sv -----
// Output channel of the trimmed-mean filter: one beat carries four means.
// Depends on tmf_pkg.
interface tmf_result_if
    import tmf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t front_filtered;
    sample_t back_filtered;
    sample_t right_one_filtered;
    sample_t right_two_filtered;

    modport source (
        output valid,
        input  ready,
        output front_filtered,
        output back_filtered,
        output right_one_filtered,
        output right_two_filtered
    );

    modport sink (
        input  valid,
        output ready,
        input  front_filtered,
        input  back_filtered,
        input  right_one_filtered,
        input  right_two_filtered
    );
endinterface

// ----- design/four_channel_trimmed_mean_filter.sv -----
// Top level of the four-channel trimmed-mean filter: write position, stage
// valids, four tmf_lane instances and tmf_merge. Depends on tmf_pkg and both interfaces.
//
//   port     dir   beat contents
//   -------  ----  ----------------------------------------------------------
//   sample   in    front_sample, back_sample, right_one_sample, right_two_sample
//   result   out   front_filtered, back_filtered, right_one_filtered,
//                  right_two_filtered
//
// One sample set per cycle while the result port takes beats; the accepting edge
// writes the window, then sum/min/max, numerator, multiply and the output register
// follow as registered stages in that order. Each stage moves forward whenever
// the stage after it is empty or moving, so bubbles close up under a stalled
// result port; input stalls only once all five stages hold a beat.
// Reset clears the windows, the write position and all stage valids.
module four_channel_trimmed_mean_filter
    import tmf_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    tmf_sample_if.sink   sample,
    tmf_result_if.source result
);

    localparam int POS_W = $clog2(WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    logic [POS_W-1:0] pos_reg;
    logic             v0_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;

    logic             rdy0;
    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             merge_open;
    logic             accept;
    lane_ctrl_t       ctrl;
    sample_t          lane_in   [CHANNELS];
    sample_t          lane_mean [CHANNELS];

    assign rdy3   = !v3_reg || merge_open;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign rdy0   = !v0_reg || rdy1;
    assign accept = sample.valid && rdy0;

    assign sample.ready = rdy0;

    assign ctrl.wr_en = accept;
    assign ctrl.s1_en = v0_reg && rdy1;
    assign ctrl.s2_en = v1_reg && rdy2;
    assign ctrl.s3_en = v2_reg && rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end
            if (rdy0)
            begin
                v0_reg <= sample.valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign lane_in[LANE_FRONT]     = sample.front_sample;
    assign lane_in[LANE_BACK]      = sample.back_sample;
    assign lane_in[LANE_RIGHT_ONE] = sample.right_one_sample;
    assign lane_in[LANE_RIGHT_TWO] = sample.right_two_sample;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        tmf_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .wr_pos (pos_reg),
            .sample (lane_in[ch]),
            .mean   (lane_mean[ch])
        );
    end

    tmf_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (v3_reg),
        .lane_mean (lane_mean),
        .open      (merge_open),
        .result    (result)
    );

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("write position out of range");

    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pos_reg != $past(pos_reg))
        else $error("write position did not advance on an accepted beat");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(v3_reg))
        else $error("result beat appeared without a finished stage");

endmodule

// ----- design/tmf_lane.sv -----
// One channel lane: ring window, sum/min/max stage, trimmed numerator and
// reciprocal multiply. Depends on tmf_pkg.
module tmf_lane
    import tmf_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic [$clog2(WINDOW)-1:0]  wr_pos,
    input  sample_t                    sample,
    output sample_t                    mean
);

    localparam int DIV    = WINDOW - 2;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int NUM_W  = SAMPLE_W + $clog2(DIV);
    localparam int SHIFT  = NUM_W + $clog2(DIV);
    localparam int MUL_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + MUL_W;
    // ceil(2^SHIFT / DIV): exact quotient for every NUM_W-bit numerator
    localparam longint RECIP = ((longint'(1) << SHIFT) + DIV - 1) / DIV;
    localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

    sample_t              win_reg [WINDOW];
    logic [SUM_W-1:0]     sum_reg;
    sample_t              min_reg;
    sample_t              max_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic [SUM_W-1:0]     sum_next;
    sample_t              min_next;
    sample_t              max_next;
    logic [SUM_W-1:0]     trim_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            win_reg[wr_pos] <= sample;
        end
    end

    always_comb
    begin
        sum_next = '0;
        min_next = '1;
        max_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            sum_next = sum_next + SUM_W'(win_reg[i]);
            if (win_reg[i] < min_next)
            begin
                min_next = win_reg[i];
            end
            if (win_reg[i] > max_next)
            begin
                max_next = win_reg[i];
            end
        end
    end

    assign trim_sum = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
        if (ctrl.s2_en)
        begin
            num_reg <= trim_sum[NUM_W-1:0];
        end
        if (ctrl.s3_en)
        begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(RECIP_C);
        end
    end

    assign mean = prod_reg[SHIFT +: SAMPLE_W];

endmodule

// ----- design/tmf_merge.sv -----
// Output register that gathers the four lane means into one result beat.
// Depends on tmf_pkg and tmf_result_if.
module tmf_merge
    import tmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sample_t       lane_mean [CHANNELS],
    output logic          open,
    tmf_result_if.source  result
);

    logic    valid_reg;
    sample_t front_reg;
    sample_t back_reg;
    sample_t right_one_reg;
    sample_t right_two_reg;

    // Take a new beat when empty or when the held one leaves this cycle
    assign open = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (open)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (open && load)
        begin
            front_reg     <= lane_mean[LANE_FRONT];
            back_reg      <= lane_mean[LANE_BACK];
            right_one_reg <= lane_mean[LANE_RIGHT_ONE];
            right_two_reg <= lane_mean[LANE_RIGHT_TWO];
        end
    end

    assign result.valid              = valid_reg;
    assign result.front_filtered     = front_reg;
    assign result.back_filtered      = back_reg;
    assign result.right_one_filtered = right_one_reg;
    assign result.right_two_filtered = right_two_reg;

endmodule
